FILE: design/assert_macros.svh
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define VFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, held off while reset is asserted.
`define VFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: design/vfc_pkg.sv
// Types and constants shared by the voxel face culling mesher.
package vfc_pkg;

    localparam int OP_W    = 2;
    localparam int XY_W    = 4;
    localparam int Z_W     = 8;
    localparam int BTYPE_W = 8;
    localparam int DIR_W   = 2;
    localparam int VTX_W   = 20;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_PROCESS = 2'd1;
    localparam logic [OP_W-1:0] OP_BEGIN   = 2'd2;

    // face directions
    localparam logic [DIR_W-1:0] DIR_MX = 2'd0;
    localparam logic [DIR_W-1:0] DIR_PX = 2'd1;
    localparam logic [DIR_W-1:0] DIR_MY = 2'd2;
    localparam logic [DIR_W-1:0] DIR_PY = 2'd3;

    localparam logic [VTX_W-1:0] VERTS_PER_FACE = 20'd4;

    // read sequence: center cell, then the four side neighbors, then evaluate
    localparam logic [2:0] PH_CENTER = 3'd0;
    localparam logic [2:0] PH_MX     = 3'd1;
    localparam logic [2:0] PH_PX     = 3'd2;
    localparam logic [2:0] PH_MY     = 3'd3;
    localparam logic [2:0] PH_PY     = 3'd4;
    localparam logic [2:0] PH_EVAL   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } vfc_state_t;

endpackage

FILE: design/vfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/voxel_face_cull_mesher.sv
// Voxel face culling mesher: solid map in RAM, four side faces per cell.
// Load, begin and ignored words are taken in S_IDLE without leaving it.
// A process word runs five serial read phases on the single RAM read port and one evaluate step,
// then moves one face word per cycle into the output register while m_tready lets it drain.
// The output register lets the next input word in while the last face waits on m_tready.
// aresetn (synchronous) clears control, the vertex index and air_type; the solid map is not cleared.
`include "assert_macros.svh"

module voxel_face_cull_mesher #(
    parameter int CHUNK_SIDE = 16,
    parameter int CHUNK_TALL = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cfg_data: air_type[7:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vfc_pkg::BTYPE_W-1:0]   cfg_data,
    // s_tdata: cell_x[3:0], cell_y[7:4], cell_z[15:8], block_type[23:16]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vfc_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: op[1:0]
    input  logic [vfc_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: face_dir[1:0], face_x[5:2], face_y[9:6], face_z[17:10],
    //          first_vertex[37:18], zero[39:38]
    output logic [vfc_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    import vfc_pkg::*;

    localparam int CellCount = CHUNK_SIDE * CHUNK_SIDE * CHUNK_TALL;
    localparam int AddrW     = $clog2(CellCount);
    localparam int NbW       = XY_W + 1;

    function automatic logic [AddrW-1:0] cell_addr(input logic [NbW-1:0] x,
                                                  input logic [NbW-1:0] y,
                                                  input logic [Z_W-1:0] z);
        cell_addr = AddrW'(x) + AddrW'(CHUNK_SIDE) *
                    (AddrW'(y) + AddrW'(CHUNK_SIDE) * AddrW'(z));
    endfunction

    vfc_state_t        state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [XY_W-1:0]   cx_reg, cx_next;
    logic [XY_W-1:0]   cy_reg, cy_next;
    logic [Z_W-1:0]    cz_reg, cz_next;
    logic [4:0]        solid_reg, solid_next;
    logic              rd_valid_reg;
    logic [3:0]        mask_reg, mask_next;
    logic [VTX_W-1:0]  vcount_reg, vcount_next;
    logic [BTYPE_W-1:0] air_type_reg, air_type_next;

    logic              mvalid_reg, mvalid_next;
    logic [DIR_W-1:0]  odir_reg, odir_next;
    logic [XY_W-1:0]   ox_reg, ox_next;
    logic [XY_W-1:0]   oy_reg, oy_next;
    logic [Z_W-1:0]    oz_reg, oz_next;
    logic [VTX_W-1:0]  ofv_reg, ofv_next;
    logic              olast_reg, olast_next;

    logic [OP_W-1:0]    in_op;
    logic [XY_W-1:0]    in_x, in_y;
    logic [Z_W-1:0]     in_z;
    logic [BTYPE_W-1:0] in_bt;
    logic               in_acc, in_chunk;

    logic               wr_en, wr_data;
    logic [AddrW-1:0]   wr_addr;
    logic [NbW-1:0]     nb_x, nb_y;
    logic               nb_ok, rd_en;
    logic [AddrW-1:0]   rd_addr;
    logic               rd_data;
    logic [4:0]         solid_shift;
    logic [3:0]         exposed;
    logic [3:0]         mask_rest;
    logic               out_load;

    assign in_op = s_tuser;
    assign in_x  = s_tdata[3:0];
    assign in_y  = s_tdata[7:4];
    assign in_z  = s_tdata[15:8];
    assign in_bt = s_tdata[23:16];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign in_chunk  = (32'(in_x) < 32'(CHUNK_SIDE)) && (32'(in_y) < 32'(CHUNK_SIDE)) &&
                       (32'(in_z) < 32'(CHUNK_TALL));

    // solid bit is fixed at load time with the current air code
    assign wr_en   = in_acc && (in_op == OP_LOAD) && in_chunk;
    assign wr_addr = cell_addr({1'b0, in_x}, {1'b0, in_y}, in_z);
    assign wr_data = (in_bt != air_type_reg);

    always_comb begin
        nb_x  = {1'b0, cx_reg};
        nb_y  = {1'b0, cy_reg};
        nb_ok = 1'b0;
        unique case (phase_reg)
            PH_CENTER: begin
                nb_ok = 1'b1;
            end
            PH_MX: begin
                nb_x  = {1'b0, cx_reg} - NbW'(1);
                nb_ok = (cx_reg != '0);
            end
            PH_PX: begin
                nb_x  = {1'b0, cx_reg} + NbW'(1);
                nb_ok = (32'(cx_reg) + 32'd1 < 32'(CHUNK_SIDE));
            end
            PH_MY: begin
                nb_y  = {1'b0, cy_reg} - NbW'(1);
                nb_ok = (cy_reg != '0);
            end
            PH_PY: begin
                nb_y  = {1'b0, cy_reg} + NbW'(1);
                nb_ok = (32'(cy_reg) + 32'd1 < 32'(CHUNK_SIDE));
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign rd_en   = (state_reg == S_READ) && nb_ok;
    assign rd_addr = cell_addr(nb_x, nb_y, cz_reg);

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (CellCount)
    ) u_solid_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read data arrives one phase late; shifted in so center ends at bit 0
    assign solid_shift = {rd_data & rd_valid_reg, solid_reg[4:1]};
    assign exposed     = ~solid_shift[4:1];
    assign mask_rest   = mask_reg & (mask_reg - 4'd1);
    assign out_load    = (state_reg == S_EMIT) && (!mvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        solid_next    = solid_reg;
        mask_next     = mask_reg;
        vcount_next   = vcount_reg;
        air_type_next = air_type_reg;
        mvalid_next   = mvalid_reg;
        odir_next     = odir_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        ofv_next      = ofv_reg;
        olast_next    = olast_reg;

        if (cfg_valid) begin
            air_type_next = cfg_data;
        end
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_BEGIN) begin
                        vcount_next = '0;
                    end else if (in_op == OP_PROCESS && in_chunk) begin
                        cx_next    = in_x;
                        cy_next    = in_y;
                        cz_next    = in_z;
                        phase_next = PH_CENTER;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                if (phase_reg != PH_CENTER) begin
                    solid_next = solid_shift;
                end
                if (phase_reg == PH_EVAL) begin
                    if (solid_shift[0] && (exposed != 4'd0)) begin
                        mask_next  = exposed;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    priority if (mask_reg[0]) begin
                        odir_next = DIR_MX;
                    end else if (mask_reg[1]) begin
                        odir_next = DIR_PX;
                    end else if (mask_reg[2]) begin
                        odir_next = DIR_MY;
                    end else begin
                        odir_next = DIR_PY;
                    end
                    ox_next     = cx_reg;
                    oy_next     = cy_reg;
                    oz_next     = cz_reg;
                    ofv_next    = vcount_reg;
                    olast_next  = (mask_rest == 4'd0);
                    mvalid_next = 1'b1;
                    vcount_next = vcount_reg + VERTS_PER_FACE;
                    mask_next   = mask_rest;
                    if (mask_rest == 4'd0) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_CENTER;
            rd_valid_reg <= 1'b0;
            mvalid_reg   <= 1'b0;
            vcount_reg   <= '0;
            air_type_reg <= '0;
            mask_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            rd_valid_reg <= rd_en;
            mvalid_reg   <= mvalid_next;
            vcount_reg   <= vcount_next;
            air_type_reg <= air_type_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        solid_reg <= solid_next;
        odir_reg  <= odir_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        ofv_reg   <= ofv_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, ofv_reg, oz_reg, oy_reg, ox_reg, odir_reg};

    `VFC_ASSERT_IMP(a_emit_has_faces, aclk, aresetn, state_reg == S_EMIT, mask_reg != 4'd0)
    `VFC_ASSERT_IMP(a_no_read_when_idle, aclk, aresetn, state_reg == S_IDLE, !rd_en)
    `VFC_ASSERT_NXT(a_process_blocks_input, aclk, aresetn,
        in_acc && in_op == OP_PROCESS && in_chunk, !s_tready)
    `VFC_ASSERT_NXT(a_index_steps, aclk, aresetn, out_load,
        vcount_reg == $past(vcount_reg) + VERTS_PER_FACE && m_tvalid)

endmodule
